// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- hw/rtl/bab_pkg.sv -----
`timescale 1ns / 1ps

package bab_pkg;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BLOCK_HEIGHT = 2'd2,
    CFG_LEVEL_STEP   = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACCUM,
    ST_DIV_AVG,
    ST_SCALE,
    ST_DIV_LVL,
    ST_EMIT
  } state_t;

  localparam logic KIND_LEVEL = 1'b0;
  localparam logic KIND_BREAK = 1'b1;

  localparam int SUM_W = 19;
  localparam int LVL_NUM_W = 26;
  localparam int DIVISOR_W = 17;

endpackage

// ----- hw/rtl/block_average_brightness_levels.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Block average downsampler for gray pixels in raster order. Each pixel
// transaction passes ST_READ and ST_ACCUM, then ST_DIV_AVG, ST_SCALE and
// ST_DIV_LVL when it ends a block, and ends in ST_EMIT, where it waits out
// any stall on the result side. A single shared restoring divider is used
// twice per finished block, 19 steps for the block average and 26 steps for
// the level, one quotient bit a cycle. Column sums live in a memory of
// MAX_IMAGE_WIDTH entries with one read and one write port, whose read is
// registered. A transaction gives at most two results (a level, then a line
// break), each held in turn in the output register until taken; the next
// pixel is taken once the last of them is loaded into it.
module block_average_brightness_levels #(
  parameter int MAX_IMAGE_WIDTH  = 4096,
  parameter int MAX_BLOCK_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_level,
  output logic        out_last
);
  import bab_pkg::*;

  localparam int COL_W = $clog2(MAX_IMAGE_WIDTH);
  localparam int CNT_W = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int BH_W  = $clog2(MAX_BLOCK_HEIGHT + 1);
  localparam int DIV_CNT_W = 5;

  logic [12:0] image_width_r, image_height_r;
  logic [6:0]  block_height_r;
  logic [15:0] level_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 13'd640;
      image_height_r <= 13'd480;
      block_height_r <= 7'd8;
      level_step_r   <= 16'd956;
    end else if (cfg_write_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[12:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[12:0];
        CFG_BLOCK_HEIGHT: block_height_r <= cfg_data[6:0];
        CFG_LEVEL_STEP:   level_step_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturated working values of the registers.
  logic [CNT_W-1:0] w;
  logic [12:0]      h;
  logic [BH_W-1:0]  bh;
  logic [BH_W-1:0]  bw;
  logic [15:0]      step;
  logic [BH_W+1:0]  bw_wide;

  always_comb begin
    if (image_width_r == 13'd0) w = CNT_W'(1);
    else if (32'(image_width_r) > MAX_IMAGE_WIDTH) w = CNT_W'(MAX_IMAGE_WIDTH);
    else w = CNT_W'(image_width_r);
    if (image_height_r == 13'd0) h = 13'd1;
    else if (image_height_r > 13'd4096) h = 13'd4096;
    else h = image_height_r;
    if (block_height_r < 7'd2) bh = BH_W'(2);
    else if (32'(block_height_r) > MAX_BLOCK_HEIGHT) bh = BH_W'(MAX_BLOCK_HEIGHT);
    else bh = BH_W'(block_height_r);
    bw_wide = ({2'b00, bh} + {1'b0, bh, 1'b0} + (BH_W+2)'(4)) >> 3;
    bw = bw_wide[BH_W-1:0];
    step = (level_step_r < 16'd256) ? 16'd256 : level_step_r;
  end

  // Position counters.
  logic [COL_W-1:0] pixel_column_r, pixel_column_nxt;
  logic [11:0]      pixel_row_r, pixel_row_nxt;
  logic [BH_W-1:0]  column_in_block_r, column_in_block_nxt;
  logic [CNT_W-1:0] block_column_r, block_column_nxt;
  logic [BH_W-1:0]  row_in_block_r, row_in_block_nxt;

  logic [SUM_W-1:0] sums [MAX_IMAGE_WIDTH];
  logic [SUM_W-1:0] rd_data_r;
  logic             mem_we;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  state_t state_r, state_nxt;
  logic [7:0] pix_r, pix_nxt;
  logic emit_lvl_r, emit_lvl_nxt, emit_brk_r, emit_brk_nxt;
  logic [7:0] lvl_r, lvl_nxt;

  // Shared divider state.
  logic [LVL_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W:0]   rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  logic [DIVISOR_W:0] rem_shift;
  logic [DIVISOR_W:0] rem_diff;

  logic [CNT_W-1:0] w_m1;
  logic [12:0] h_m1;
  logic col_end, row_end, cib_last, rib_last, col_ok, row_ok, block_in_mem;
  logic [CNT_W+BH_W:0] col_span;
  logic [13+BH_W:0]    row_span;
  logic [2*BH_W-1:0]   area;

  always_comb begin
    w_m1 = w - CNT_W'(1);
    h_m1 = h - 13'd1;
    col_end = CNT_W'(pixel_column_r) >= w_m1;
    row_end = 13'(pixel_row_r) >= h_m1;
    cib_last = column_in_block_r == bw - BH_W'(1);
    rib_last = row_in_block_r == bh - BH_W'(1);
    col_span = (CNT_W+BH_W+1)'(pixel_column_r) - (CNT_W+BH_W+1)'(column_in_block_r)
      + (CNT_W+BH_W+1)'(bw);
    col_ok = (CNT_W'(column_in_block_r) <= CNT_W'(pixel_column_r))
      && (col_span < (CNT_W+BH_W+1)'(w));
    row_span = (14+BH_W)'(pixel_row_r) - (14+BH_W)'(row_in_block_r) + (14+BH_W)'(bh);
    row_ok = (12'(row_in_block_r) <= pixel_row_r) && (row_span < (14+BH_W)'(h));
    block_in_mem = block_column_r < CNT_W'(MAX_IMAGE_WIDTH);
    area = (2*BH_W)'(bw) * (2*BH_W)'(bh);
    rem_shift = {rem_r[DIVISOR_W-1:0], quo_r[LVL_NUM_W-1]};
    rem_diff = rem_shift - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (mem_we) sums[block_column_r[COL_W-1:0]] <= sum_r;
    rd_data_r <= sums[block_column_r[COL_W-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    pix_nxt = pix_r;
    sum_nxt = sum_r;
    emit_lvl_nxt = emit_lvl_r;
    emit_brk_nxt = emit_brk_r;
    lvl_nxt = lvl_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    mem_we = 1'b0;
    pixel_column_nxt = pixel_column_r;
    pixel_row_nxt = pixel_row_r;
    column_in_block_nxt = column_in_block_r;
    block_column_nxt = block_column_r;
    row_in_block_nxt = row_in_block_r;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          pix_nxt = in_pixel_value;
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_ACCUM;
      ST_ACCUM: begin
        if (column_in_block_r == '0 && row_in_block_r == '0) sum_nxt = SUM_W'(pix_r);
        else sum_nxt = rd_data_r + SUM_W'(pix_r);
        if (!block_in_mem) sum_nxt = '0;
        emit_lvl_nxt = row_ok && col_ok && rib_last && cib_last;
        emit_brk_nxt = row_ok && rib_last && col_end;
        lvl_nxt = '0;
        quo_nxt = LVL_NUM_W'(sum_nxt) << (LVL_NUM_W - SUM_W);
        rem_nxt = '0;
        den_nxt = DIVISOR_W'(area);
        cnt_nxt = DIV_CNT_W'(SUM_W - 1);
        state_nxt = (emit_lvl_nxt) ? ST_DIV_AVG
                  : (emit_brk_nxt) ? ST_EMIT : ST_EMIT;
      end
      ST_DIV_AVG, ST_DIV_LVL: begin
        if (!rem_diff[DIVISOR_W]) begin
          rem_nxt = rem_diff;
          quo_nxt = {quo_r[LVL_NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift;
          quo_nxt = {quo_r[LVL_NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) state_nxt = (state_r == ST_DIV_AVG) ? ST_SCALE : ST_EMIT;
        if (cnt_r == '0 && state_r == ST_DIV_LVL) lvl_nxt = quo_nxt[7:0];
      end
      ST_SCALE: begin
        // level = (avg * 512 + step) / (2 * step)
        quo_nxt = (LVL_NUM_W'(quo_r[7:0]) << 9) + LVL_NUM_W'(step);
        rem_nxt = '0;
        den_nxt = {step, 1'b0};
        cnt_nxt = DIV_CNT_W'(LVL_NUM_W - 1);
        state_nxt = ST_DIV_LVL;
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          if (emit_lvl_r || emit_brk_r) begin
            if (emit_lvl_r) emit_lvl_nxt = 1'b0;
            else emit_brk_nxt = 1'b0;
          end
          if (!(emit_lvl_r && emit_brk_r)) begin
            state_nxt = ST_IDLE;
            mem_we = block_in_mem;
            if (col_end) begin
              pixel_column_nxt = '0;
              column_in_block_nxt = '0;
              block_column_nxt = '0;
              if (row_end) begin
                pixel_row_nxt = '0;
                row_in_block_nxt = '0;
              end else begin
                pixel_row_nxt = pixel_row_r + 12'd1;
                row_in_block_nxt = (row_in_block_r >= bh - BH_W'(1)) ? '0
                                 : row_in_block_r + BH_W'(1);
              end
            end else begin
              pixel_column_nxt = pixel_column_r + COL_W'(1);
              if (column_in_block_r >= bw - BH_W'(1)) begin
                column_in_block_nxt = '0;
                block_column_nxt = block_column_r + CNT_W'(1);
              end else begin
                column_in_block_nxt = column_in_block_r + BH_W'(1);
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: loaded in ST_EMIT when free or being taken.
  logic out_valid_r, out_kind_r, out_last_r;
  logic [7:0] out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      pixel_column_r <= '0;
      pixel_row_r <= '0;
      column_in_block_r <= '0;
      block_column_r <= '0;
      row_in_block_r <= '0;
      emit_lvl_r <= 1'b0;
      emit_brk_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pixel_column_r <= pixel_column_nxt;
      pixel_row_r <= pixel_row_nxt;
      column_in_block_r <= column_in_block_nxt;
      block_column_r <= block_column_nxt;
      row_in_block_r <= row_in_block_nxt;
      emit_lvl_r <= emit_lvl_nxt;
      emit_brk_r <= emit_brk_nxt;
      if (state_r == ST_EMIT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= emit_lvl_r || emit_brk_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
    sum_r <= sum_nxt;
    lvl_r <= lvl_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (state_r == ST_EMIT && (!out_valid_r || !out_stall)) begin
      out_kind_r  <= emit_lvl_r ? KIND_LEVEL : KIND_BREAK;
      out_level_r <= emit_lvl_r ? lvl_r : 8'd0;
      out_last_r  <= !(emit_lvl_r && emit_brk_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_level = out_level_r;
  assign out_last  = out_last_r;

  `ASSERT_IMPL(a_stall_when_busy, clk, rst_n, state_r != ST_IDLE, in_stall, "pixel taken while busy")
  `ASSERT_IMPL(a_break_level_zero, clk, rst_n, out_valid && out_kind == KIND_BREAK, out_level == 8'd0, "line break carries a level")
  `ASSERT_IMPL(a_break_is_last, clk, rst_n, out_valid && out_kind == KIND_BREAK, out_last, "line break not last")
  `ASSERT_IMPL(a_hold_stalled, clk, rst_n, out_valid && out_stall, ##1 (out_valid && $stable(out_level) && $stable(out_kind)), "stalled result changed")

endmodule
